FILE: src/framed_packet_deframer_crc8_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet deframer
// Implication checks clocked on clk_i, inactive while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_DEFRAMER_CRC8_ASSERT_SVH
`define FRAMED_PACKET_DEFRAMER_CRC8_ASSERT_SVH

// same-cycle implication
`define FPD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/fpd_crc8_pkg.sv
// ----------------------------------------------------------------------------
// fpd_crc8_pkg
// Shared constants, types and CRC-8 helpers for the packet deframer.
// ----------------------------------------------------------------------------
package fpd_crc8_pkg;

  localparam int unsigned WindowDepth = 7;
  localparam int unsigned FillW       = 3;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned CrcMsgW     = 40;

  localparam logic [7:0] CrcPoly     = 8'h8C;
  localparam logic [7:0] HeaderReset = 8'h41;
  localparam logic [7:0] FooterReset = 8'h42;

  typedef enum logic [CfgIdxW-1:0] {
    RegHeader = 8'd0,
    RegFooter = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic        hit;
    logic [7:0]  command;
    logic [31:0] payload;
  } match_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int b = 0; b < 8; b++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  function automatic logic [CrcMsgW-1:0][7:0] crc8_columns();
    logic [CrcMsgW-1:0][7:0] cols;
    logic [CrcMsgW-1:0]      msg;
    logic [7:0]              c;
    for (int k = 0; k < CrcMsgW; k++) begin
      msg    = '0;
      msg[k] = 1'b1;
      c      = '0;
      for (int i = 0; i < CrcMsgW / 8; i++) begin
        c = crc8_byte(c, msg[8*i +: 8]);
      end
      cols[k] = c;
    end
    return cols;
  endfunction

  localparam logic [CrcMsgW-1:0][7:0] CrcCols = crc8_columns();

  // CRC over five bytes as an XOR of per-bit columns, first byte in bits 7:0
  function automatic logic [7:0] crc8_five(logic [CrcMsgW-1:0] msg);
    logic [7:0] c;
    c = '0;
    for (int k = 0; k < CrcMsgW; k++) begin
      if (msg[k]) begin
        c = c ^ CrcCols[k];
      end
    end
    return c;
  endfunction

endpackage

FILE: src/fpd_crc8_match.sv
// ----------------------------------------------------------------------------
// fpd_crc8_match
// Checks a full window plus the new byte for header, footer and CRC-8.
// ----------------------------------------------------------------------------
module fpd_crc8_match (
  input  logic [fpd_crc8_pkg::WindowDepth-1:0][7:0] window_i,
  input  logic [7:0]                                rx_byte_i,
  input  logic [7:0]                                header_i,
  input  logic [7:0]                                footer_i,
  output fpd_crc8_pkg::match_t                      match_o
);

  logic [fpd_crc8_pkg::CrcMsgW-1:0] msg;
  logic [7:0]                       crc;

  assign msg = {window_i[5], window_i[4], window_i[3], window_i[2], window_i[1]};
  assign crc = fpd_crc8_pkg::crc8_five(msg);

  always_comb begin
    match_o.hit     = (window_i[0] == header_i) && (rx_byte_i == footer_i) &&
                      (window_i[6] == crc);
    match_o.command = window_i[1];
    match_o.payload = {window_i[5], window_i[4], window_i[3], window_i[2]};
  end

endmodule

FILE: src/framed_packet_deframer_crc8.sv
// ----------------------------------------------------------------------------
// framed_packet_deframer_crc8
// Byte-stream deframer: finds header/footer framed packets with CRC-8.
// ----------------------------------------------------------------------------
// Bytes enter on the in channel (in_valid_i/in_ready_o, rx_byte_i), one per
// item. Eight consecutive bytes form a packet when the first equals the header
// register, the last equals the footer register and byte 6 equals the CRC-8
// (reflected poly 0x8C, init 0) over bytes 1..5. Each packet gives one item on
// the out channel: command_o (byte 1) and payload_o (bytes 2..5, LSB first).
// A matched packet empties the window; a failed check drops the oldest byte.
// A byte is first held in the input register; its result, if any, is then
// written to the output register when the output side can take it.
// One byte per cycle is taken while no result is stalled, as the window
// update and CRC check between the two registers are combinational.
// The cfg channel writes header (index 0) or footer (index 1); other indexes
// are ignored. Write only while the block is idle.
// Reset empties the window and loads header 'A' and footer 'B'.
// When the receiver stalls a pending result, the input register fills and
// in_ready_o drops until out_ready_i returns.
// ----------------------------------------------------------------------------
`include "framed_packet_deframer_crc8_assert.svh"

module framed_packet_deframer_crc8 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        command_o,
  output logic [31:0]                       payload_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpd_crc8_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);

  localparam logic [fpd_crc8_pkg::FillW-1:0] FillFull =
    fpd_crc8_pkg::FillW'(fpd_crc8_pkg::WindowDepth);

  logic [7:0]                                header_q;
  logic [7:0]                                footer_q;
  logic                                      in_vld_q;
  logic [7:0]                                in_byte_q;
  logic [fpd_crc8_pkg::WindowDepth-1:0][7:0] win_q;
  logic [fpd_crc8_pkg::FillW-1:0]            fill_q;
  logic                                      out_vld_q;
  logic [7:0]                                cmd_q;
  logic [31:0]                               pay_q;
  logic                                      full;
  logic                                      adv;
  logic                                      in_fire;
  fpd_crc8_pkg::match_t                      match;

  assign full        = (fill_q == FillFull);
  assign adv         = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  fpd_crc8_match u_match (
    .window_i  (win_q),
    .rx_byte_i (in_byte_q),
    .header_i  (header_q),
    .footer_i  (footer_q),
    .match_o   (match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= fpd_crc8_pkg::HeaderReset;
      footer_q <= fpd_crc8_pkg::FooterReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fpd_crc8_pkg::RegHeader: header_q <= cfg_data_i;
        fpd_crc8_pkg::RegFooter: footer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // advance the window: append while filling, clear on a match, else slide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (adv) begin
      if (!full) begin
        fill_q <= fill_q + 1'b1;
      end else if (match.hit) begin
        fill_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!full) begin
        win_q[fill_q] <= in_byte_q;
      end else if (!match.hit) begin
        for (int i = 0; i < fpd_crc8_pkg::WindowDepth - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[fpd_crc8_pkg::WindowDepth-1] <= in_byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= full && match.hit;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && full && match.hit) begin
      cmd_q <= match.command;
      pay_q <= match.payload;
    end
  end

  assign out_valid_o = out_vld_q;
  assign command_o   = cmd_q;
  assign payload_o   = pay_q;

  `FPD_ASSERT_NEXT(a_match_empties_window, adv && full && match.hit, fill_q == '0)
  `FPD_ASSERT_NEXT(a_no_item_before_full, adv && !full, !out_vld_q)
  `FPD_ASSERT_SAME(a_stall_blocks_input, in_vld_q && out_vld_q && !out_ready_i, !in_ready_o)

endmodule

FILE: dv/deframer_frame_checker.sv
// ----------------------------------------------------------------------------
// Deframer frame checker
// Watches the byte, result and register channels of the packet deframer,
// keeps its own byte window and register copies, works out which frames the
// block must report and compares every reported item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deframer_frame_checker
  import fpd_crc8_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [7:0]          command_i,
  input  logic [31:0]         payload_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output int unsigned         errors_o,
  output int unsigned         frames_due_o
);

  typedef struct packed {
    logic [7:0]  command;
    logic [31:0] payload;
  } frame_t;

  logic [7:0]  header_q;
  logic [7:0]  footer_q;
  logic [7:0]  window_q [WindowDepth];
  int unsigned fill_q;
  int unsigned errors_q;
  frame_t      frames_due [$];

  // Dallas/Maxim CRC-8, first byte in bits 7:0, LSB of each byte first
  function automatic logic [7:0] maxim_crc8(input logic [39:0] body);
    logic [7:0] crc;
    logic       fb;
    crc = 8'h00;
    for (int k = 0; k < 40; k++) begin
      fb  = crc[0] ^ body[k];
      crc = {1'b0, crc[7:1]} ^ (fb ? 8'h8C : 8'h00);
    end
    return crc;
  endfunction

  task automatic take_byte(input logic [7:0] rx);
    logic [7:0]  pkt [WindowDepth+1];
    logic [39:0] body;
    if (fill_q < WindowDepth) begin
      window_q[fill_q] = rx;
      fill_q++;
    end else begin
      for (int i = 0; i < WindowDepth; i++) pkt[i] = window_q[i];
      pkt[WindowDepth] = rx;
      body = {pkt[5], pkt[4], pkt[3], pkt[2], pkt[1]};
      if (pkt[0] == header_q && pkt[7] == footer_q && pkt[6] == maxim_crc8(body)) begin
        frames_due.push_back('{command: pkt[1], payload: {pkt[5], pkt[4], pkt[3], pkt[2]}});
        for (int i = 0; i < WindowDepth; i++) window_q[i] = 8'h00;
        fill_q = 0;
      end else begin
        // drop the oldest byte
        for (int i = 0; i < WindowDepth; i++) window_q[i] = pkt[i+1];
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t want;
    if (!rst_ni) begin
      header_q = HeaderReset;
      footer_q = FooterReset;
      for (int i = 0; i < WindowDepth; i++) window_q[i] = 8'h00;
      fill_q   = 0;
      errors_q = 0;
      frames_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegHeader: header_q = cfg_data_i;
          RegFooter: footer_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual command %h payload %h",
                   $time, command_i, payload_i);
          errors_q++;
        end else begin
          want = frames_due.pop_front();
          if (command_i !== want.command) begin
            $display("%0t: command mismatch, expected %h, actual %h",
                     $time, want.command, command_i);
            errors_q++;
          end
          if (payload_i !== want.payload) begin
            $display("%0t: payload mismatch, expected %h, actual %h",
                     $time, want.payload, payload_i);
            errors_q++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        take_byte(rx_byte_i);
      end
    end
    errors_o     <= errors_q;
    frames_due_o <= frames_due.size();
  end

endmodule

FILE: dv/framed_packet_deframer_crc8_tb.sv
// ----------------------------------------------------------------------------
// Packet deframer testbench
// Feeds framed, corrupted and stray bytes under several header and footer
// settings, with random gaps on the byte channel and random stalls on the
// result channel; the frame checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_packet_deframer_crc8_tb;
  import fpd_crc8_pkg::*;

  localparam int unsigned ItemsPerPhase = 330;
  localparam int unsigned SettleCycles  = 4;
  localparam logic [CfgIdxW-1:0] RegUnused = 8'hFF;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         command_o;
  logic [31:0]        payload_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [7:0]         cfg_data_i;

  int unsigned check_errors;
  int unsigned frames_due;
  logic [7:0]  cur_header;
  logic [7:0]  cur_footer;
  bit          quiet_in;
  int unsigned bytes_sent;

  framed_packet_deframer_crc8 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .command_o   (command_o),
    .payload_o   (payload_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  deframer_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .command_i    (command_o),
    .payload_i    (payload_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (check_errors),
    .frames_due_o (frames_due)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = quiet_in ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // bad_pos < 0 leaves the frame intact
  task automatic send_frame(input logic [7:0] cmd, input logic [31:0] data, input int bad_pos);
    logic [7:0] pkt [8];
    pkt[0] = cur_header;
    pkt[1] = cmd;
    for (int i = 0; i < 4; i++) pkt[2+i] = data[8*i +: 8];
    pkt[6] = crc8_five({data, cmd});
    pkt[7] = cur_footer;
    if (bad_pos >= 0) pkt[bad_pos] = pkt[bad_pos] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 8; i++) push_byte(pkt[i]);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegHeader) cur_header = data;
    if (idx == RegFooter) cur_footer = data;
  endtask

  // hold the sender until every frame has come out and the pipeline is empty
  task automatic quiesce();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (frames_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned r;
    logic [31:0] data;
    quiet_in   = ($urandom_range(0, 3) == 0);
    bytes_sent = 0;
    while (bytes_sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        data = (r < 10) ? 32'h0000_0000 : (r < 20) ? 32'hFFFF_FFFF : $urandom;
        send_frame(8'($urandom_range(0, 255)), data,
                   ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 7)) : -1);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 49) == 0) quiet_in = !quiet_in;
    end
  endtask

  task automatic run_phase(input logic [7:0] hdr, input logic [7:0] ftr);
    quiesce();
    write_reg(RegHeader, hdr);
    write_reg(RegFooter, ftr);
    write_reg(8'($urandom_range(RegFooter + 1, RegUnused)), 8'($urandom_range(0, 255)));
    random_traffic(ItemsPerPhase);
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int unsigned run;
      int unsigned stall;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegHeader;
    cfg_data_i  = 8'h00;
    cur_header  = HeaderReset;
    cur_footer  = FooterReset;
    quiet_in    = 1'b0;
    bytes_sent  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(8'h00, 32'h0000_0000, -1);
    push_byte(8'h5A);
    send_frame(8'hFF, 32'hFFFF_FFFF, -1);
    send_frame(8'h3C, 32'h1234_5678, 6);
    random_traffic(ItemsPerPhase);

    run_phase(8'h00, 8'hFF);
    run_phase(8'hFF, 8'h00);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(8'h00, 8'h00);
    run_phase(8'hFF, 8'hFF);

    quiesce();
    if (check_errors == 0 && frames_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
